// ----- src/sha256_byte_stream_hasher_macros.svh -----
// assertion macros for the byte stream hasher checker
`ifndef SHA256_BYTE_STREAM_HASHER_MACROS_SVH
`define SHA256_BYTE_STREAM_HASHER_MACROS_SVH

// same-cycle implication
`define SHABS_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("shabs check failed");

// next-cycle implication
`define SHABS_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("shabs check failed");

`endif

// ----- src/shabs_pkg.sv -----
package shabs_pkg;

  localparam int CNT_W  = 61;

  localparam logic [31:0] ROUND_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam logic [31:0] INIT_H [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  typedef struct packed {
    logic       take_byte;
    logic       pad;
    logic       clr;
    logic       len;
    logic       load;
    logic       round;
    logic       add;
    logic       emit;
    logic [5:0] rnd;
  } shabs_cmd_t;

  typedef struct packed {
    logic blk_full;
    logic pad_wraps;
    logic obuf_busy;
  } shabs_sts_t;

  function automatic logic [31:0] big_sig0(input logic [31:0] x);
    big_sig0 = {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
  endfunction

  function automatic logic [31:0] big_sig1(input logic [31:0] x);
    big_sig1 = {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
  endfunction

  function automatic logic [31:0] small_sig0(input logic [31:0] x);
    small_sig0 = {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
  endfunction

  function automatic logic [31:0] small_sig1(input logic [31:0] x);
    small_sig1 = {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'd0, x[31:10]};
  endfunction

endpackage

// ----- src/shabs_ctrl.sv -----
module shabs_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  in_byte_present,
  input  logic                  in_end_of_message,
  input  shabs_pkg::shabs_sts_t sts,
  output shabs_pkg::shabs_cmd_t cmd
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_LOAD  = 3'd1;
  localparam logic [2:0] ST_ROUND = 3'd2;
  localparam logic [2:0] ST_ADD   = 3'd3;
  localparam logic [2:0] ST_PAD   = 3'd4;
  localparam logic [2:0] ST_CLR   = 3'd5;
  localparam logic [2:0] ST_LEN   = 3'd6;
  localparam logic [2:0] ST_DONE  = 3'd7;

  // what follows a compression
  localparam logic [1:0] PH_BLK  = 2'd0;
  localparam logic [1:0] PH_WRAP = 2'd1;
  localparam logic [1:0] PH_FIN  = 2'd2;

  logic [2:0] state_r, state_nxt;
  logic [1:0] phase_r, phase_nxt;
  logic [5:0] rnd_r, rnd_nxt;
  logic       eom_r, eom_nxt;
  logic       accept;

  assign in_ready = (state_r == ST_IDLE);
  assign accept   = in_valid & in_ready;

  always_comb begin
    cmd           = '0;
    cmd.take_byte = accept & in_byte_present;
    cmd.pad       = (state_r == ST_PAD);
    cmd.clr       = (state_r == ST_CLR);
    cmd.len       = (state_r == ST_LEN);
    cmd.load      = (state_r == ST_LOAD);
    cmd.round     = (state_r == ST_ROUND);
    cmd.add       = (state_r == ST_ADD);
    cmd.emit      = (state_r == ST_DONE) & ~sts.obuf_busy;
    cmd.rnd       = rnd_r;
  end

  always_comb begin
    state_nxt = state_r;
    phase_nxt = phase_r;
    rnd_nxt   = rnd_r;
    eom_nxt   = eom_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          eom_nxt = in_end_of_message;
          if (in_byte_present && sts.blk_full) begin
            phase_nxt = PH_BLK;
            state_nxt = ST_LOAD;
          end else if (in_end_of_message) begin
            state_nxt = ST_PAD;
          end
        end
      end
      ST_LOAD: begin
        rnd_nxt   = 6'd0;
        state_nxt = ST_ROUND;
      end
      ST_ROUND: begin
        rnd_nxt = rnd_r + 6'd1;
        if (rnd_r == 6'd63) begin
          state_nxt = ST_ADD;
        end
      end
      ST_ADD: begin
        unique case (phase_r)
          PH_BLK:  state_nxt = eom_r ? ST_PAD : ST_IDLE;
          PH_WRAP: state_nxt = ST_CLR;
          PH_FIN:  state_nxt = ST_DONE;
          default: state_nxt = ST_IDLE;
        endcase
      end
      ST_PAD: begin
        // length does not fit behind the pad byte: one extra block
        if (sts.pad_wraps) begin
          phase_nxt = PH_WRAP;
          state_nxt = ST_LOAD;
        end else begin
          state_nxt = ST_LEN;
        end
      end
      ST_CLR: begin
        state_nxt = ST_LEN;
      end
      ST_LEN: begin
        phase_nxt = PH_FIN;
        state_nxt = ST_LOAD;
      end
      ST_DONE: begin
        if (!sts.obuf_busy) begin
          state_nxt = ST_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      phase_r <= PH_BLK;
      rnd_r   <= 6'd0;
      eom_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      phase_r <= phase_nxt;
      rnd_r   <= rnd_nxt;
      eom_r   <= eom_nxt;
    end
  end

endmodule

// ----- src/shabs_dp.sv -----
module shabs_dp (
  input  logic                  clk,
  input  logic                  rst_n,
  input  shabs_pkg::shabs_cmd_t cmd,
  output shabs_pkg::shabs_sts_t sts,
  input  logic [7:0]            in_data_byte,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [31:0]           out_digest_word,
  output logic [2:0]            out_word_index,
  output logic                  out_last_word
);

  logic [31:0] w_r [16];
  logic [31:0] w_nxt [16];
  logic [31:0] v_r [8];
  logic [31:0] v_nxt [8];
  logic [31:0] h_r [8];
  logic [31:0] h_nxt [8];
  logic [31:0] obuf_r [8];
  logic [31:0] obuf_nxt [8];
  logic [shabs_pkg::CNT_W-1:0] cnt_r, cnt_nxt;
  logic [3:0]  oleft_r, oleft_nxt;
  logic [2:0]  oidx_r, oidx_nxt;

  logic [5:0]  pos;
  logic [3:0]  widx;
  logic [1:0]  lane;
  logic [63:0] bit_len;
  logic [31:0] sched, wt, t1, t2;
  logic        out_take;

  assign pos     = cnt_r[5:0];
  assign widx    = pos[5:2];
  assign lane    = pos[1:0];
  assign bit_len = {cnt_r, 3'b000};

  assign sts.blk_full  = (pos == 6'd63);
  assign sts.pad_wraps = (pos >= 6'd56);
  assign sts.obuf_busy = (oleft_r != 4'd0);

  // message schedule: the window shifts one word per round
  assign sched = shabs_pkg::small_sig1(w_r[14]) + w_r[9]
               + shabs_pkg::small_sig0(w_r[1]) + w_r[0];
  assign wt    = (cmd.rnd[5:4] == 2'b00) ? w_r[0] : sched;

  assign t1 = v_r[7] + shabs_pkg::big_sig1(v_r[4])
            + ((v_r[4] & v_r[5]) ^ (~v_r[4] & v_r[6]))
            + shabs_pkg::ROUND_K[cmd.rnd] + wt;
  assign t2 = shabs_pkg::big_sig0(v_r[0])
            + ((v_r[0] & v_r[1]) ^ (v_r[0] & v_r[2]) ^ (v_r[1] & v_r[2]));

  always_comb begin
    w_nxt = w_r;
    if (cmd.take_byte) begin
      unique case (lane)
        2'd0: w_nxt[widx][31:24] = in_data_byte;
        2'd1: w_nxt[widx][23:16] = in_data_byte;
        2'd2: w_nxt[widx][15:8]  = in_data_byte;
        2'd3: w_nxt[widx][7:0]   = in_data_byte;
      endcase
    end else if (cmd.pad) begin
      for (int i = 0; i < 16; i++) begin
        if (4'(i) > widx) begin
          w_nxt[i] = 32'd0;
        end else if (4'(i) == widx) begin
          unique case (lane)
            2'd0: w_nxt[i] = 32'h8000_0000;
            2'd1: w_nxt[i] = {w_r[i][31:24], 24'h80_0000};
            2'd2: w_nxt[i] = {w_r[i][31:16], 16'h8000};
            2'd3: w_nxt[i] = {w_r[i][31:8], 8'h80};
          endcase
        end
      end
    end else if (cmd.clr) begin
      for (int i = 0; i < 16; i++) begin
        w_nxt[i] = 32'd0;
      end
    end else if (cmd.len) begin
      w_nxt[14] = bit_len[63:32];
      w_nxt[15] = bit_len[31:0];
    end else if (cmd.round) begin
      for (int i = 0; i < 15; i++) begin
        w_nxt[i] = w_r[i+1];
      end
      w_nxt[15] = wt;
    end
  end

  always_comb begin
    v_nxt = v_r;
    if (cmd.load) begin
      v_nxt = h_r;
    end else if (cmd.round) begin
      for (int i = 1; i < 8; i++) begin
        v_nxt[i] = v_r[i-1];
      end
      v_nxt[4] = v_r[3] + t1;
      v_nxt[0] = t1 + t2;
    end
  end

  always_comb begin
    h_nxt   = h_r;
    cnt_nxt = cnt_r;
    if (cmd.add) begin
      for (int i = 0; i < 8; i++) begin
        h_nxt[i] = h_r[i] + v_r[i];
      end
    end else if (cmd.emit) begin
      h_nxt   = shabs_pkg::INIT_H;
      cnt_nxt = '0;
    end else if (cmd.take_byte) begin
      cnt_nxt = cnt_r + {{(shabs_pkg::CNT_W-1){1'b0}}, 1'b1};
    end
  end

  // digest drains from its own buffer while the next message streams in
  assign out_take = out_valid & out_ready;

  always_comb begin
    obuf_nxt  = obuf_r;
    oleft_nxt = oleft_r;
    oidx_nxt  = oidx_r;
    if (cmd.emit) begin
      obuf_nxt  = h_r;
      oleft_nxt = 4'd8;
      oidx_nxt  = 3'd0;
    end else if (out_take) begin
      for (int i = 0; i < 7; i++) begin
        obuf_nxt[i] = obuf_r[i+1];
      end
      oleft_nxt = oleft_r - 4'd1;
      oidx_nxt  = oidx_r + 3'd1;
    end
  end

  assign out_valid       = (oleft_r != 4'd0);
  assign out_digest_word = obuf_r[0];
  assign out_word_index  = oidx_r;
  assign out_last_word   = (oidx_r == 3'd7);

  always_ff @(posedge clk) begin
    w_r    <= w_nxt;
    v_r    <= v_nxt;
    obuf_r <= obuf_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      h_r     <= shabs_pkg::INIT_H;
      cnt_r   <= '0;
      oleft_r <= 4'd0;
      oidx_r  <= 3'd0;
    end else begin
      h_r     <= h_nxt;
      cnt_r   <= cnt_nxt;
      oleft_r <= oleft_nxt;
      oidx_r  <= oidx_nxt;
    end
  end

endmodule

// ----- src/sha256_byte_stream_hasher.sv -----
// channel | direction | payload                                   | handshake
// in_     | input     | data_byte[7:0], byte_present, end_of_message | in_valid / in_ready
// out_    | output    | digest_word[31:0], word_index[2:0], last_word | out_valid / out_ready
//
// a word that neither fills a block nor ends the message is taken, ready again the next cycle
// a word that fills a block: accept, load, 64 rounds at one per cycle, add; end of message:
// accept, pad, length, load, 64 rounds, add, digest handoff; a length that spills adds load,
// 64 rounds, add, clear after pad; digest words leave one per cycle while out_ready is high
// the next message streams in while the digest drains; a second end waits for the buffer
// rst_n is synchronous: hash values return to the initial constants, byte count clears
module sha256_byte_stream_hasher (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_data_byte,
  input  logic        in_byte_present,
  input  logic        in_end_of_message,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_digest_word,
  output logic [2:0]  out_word_index,
  output logic        out_last_word
);

  shabs_pkg::shabs_cmd_t cmd;
  shabs_pkg::shabs_sts_t sts;

  shabs_ctrl u_ctrl (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_byte_present   (in_byte_present),
    .in_end_of_message (in_end_of_message),
    .sts               (sts),
    .cmd               (cmd)
  );

  shabs_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .in_data_byte    (in_data_byte),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_digest_word (out_digest_word),
    .out_word_index  (out_word_index),
    .out_last_word   (out_last_word)
  );

endmodule

// ----- src/shabs_chk.sv -----
`include "sha256_byte_stream_hasher_macros.svh"

module shabs_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        in_byte_present,
  input logic        in_end_of_message,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] out_digest_word,
  input logic [2:0]  out_word_index,
  input logic        out_last_word
);

  // a stalled word holds
  `SHABS_ASSERT_NXT(a_out_hold, out_valid && !out_ready,
    out_valid && $stable(out_digest_word) && $stable(out_word_index))

  // last flag marks index seven only
  `SHABS_ASSERT_IMP(a_last_idx, out_valid, out_last_word == (out_word_index == 3'd7))

  // digest words follow each other in order without a gap
  `SHABS_ASSERT_NXT(a_idx_seq, out_valid && out_ready && !out_last_word,
    out_valid && (out_word_index == 3'($past(out_word_index) + 3'd1)))

  // an empty word leaves the input side ready
  `SHABS_ASSERT_NXT(a_idle_ready,
    in_valid && in_ready && !in_byte_present && !in_end_of_message, in_ready)

endmodule

bind sha256_byte_stream_hasher shabs_chk u_chk (.*);

// ----- test/tb.sv -----
module tb;

  localparam int HOLD_LEN   = 600;
  localparam int WATCHDOG   = 5000;
  localparam int DRAIN_WAIT = 200;
  localparam int ITEM_GOAL  = 430;

  typedef enum int {PH_FREE, PH_SRC_IDLE, PH_SNK_STALL, PH_BOTH} pace_t;

  typedef struct {
    logic [7:0] data;
    logic       present;
    logic       eom;
    pace_t      phase;
  } feed_t;

  typedef struct {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
  } digest_exp_t;

  localparam logic [31:0] SHA_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam logic [31:0] SHA_H0 [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  in_data_byte = 8'h00;
  logic        in_byte_present = 1'b0;
  logic        in_end_of_message = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [31:0] out_digest_word;
  logic [2:0]  out_word_index;
  logic        out_last_word;

  sha256_byte_stream_hasher uut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_data_byte      (in_data_byte),
    .in_byte_present   (in_byte_present),
    .in_end_of_message (in_end_of_message),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_digest_word   (out_digest_word),
    .out_word_index    (out_word_index),
    .out_last_word     (out_last_word)
  );

  feed_t       feed_q[$];
  digest_exp_t digest_q[$];

  int    n_sent = 0;
  int    n_taken = 0;
  int    n_results = 0;
  int    n_msgs = 0;
  int    n_bytes = 0;
  int    n_errors = 0;
  int    stuck = 0;
  int    counted = 0;
  int    hold_at = 0;
  int    hold_cnt = 0;
  logic  hold_done = 1'b0;
  pace_t cur_phase = PH_FREE;

  // predictor state
  logic [31:0] hv [8];
  logic [31:0] blk [16];
  logic [31:0] wsched [16];
  logic [60:0] nbytes;

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic int idle_pct(input pace_t p);
    case (p)
      PH_SRC_IDLE: return 54;
      PH_BOTH:     return 34;
      default:     return 0;
    endcase
  endfunction

  function automatic int stall_pct(input pace_t p);
    case (p)
      PH_SNK_STALL: return 54;
      PH_BOTH:      return 34;
      default:      return 0;
    endcase
  endfunction

  function automatic logic [31:0] ror(input logic [31:0] x, input int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  task automatic sha_compress();
    logic [31:0] v [8];
    logic [31:0] w, t1, t2, s2, s15;
    for (int i = 0; i < 8; i++) v[i] = hv[i];
    for (int t = 0; t < 64; t++) begin
      if (t < 16) begin
        w = blk[t];
      end else begin
        s2  = wsched[(t - 2) & 15];
        s15 = wsched[(t - 15) & 15];
        w = (ror(s2, 17) ^ ror(s2, 19) ^ (s2 >> 10)) + wsched[(t - 7) & 15]
          + (ror(s15, 7) ^ ror(s15, 18) ^ (s15 >> 3)) + wsched[t & 15];
      end
      wsched[t & 15] = w;
      t1 = v[7] + (ror(v[4], 6) ^ ror(v[4], 11) ^ ror(v[4], 25))
         + ((v[4] & v[5]) ^ (~v[4] & v[6])) + SHA_K[t] + w;
      t2 = (ror(v[0], 2) ^ ror(v[0], 13) ^ ror(v[0], 22))
         + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      for (int i = 7; i > 0; i--) v[i] = v[i - 1];
      v[4] = v[4] + t1;
      v[0] = t1 + t2;
    end
    for (int i = 0; i < 8; i++) hv[i] = hv[i] + v[i];
  endtask

  task automatic place_byte(input int pos, input logic [31:0] val);
    int idx;
    int sh;
    idx = (pos >> 2) & 15;
    sh = (3 - (pos & 3)) * 8;
    if ((pos & 3) == 0) blk[idx] = val << sh;
    else blk[idx] = (blk[idx] & ~(32'hff << sh)) | (val << sh);
  endtask

  task automatic sha_restart();
    for (int i = 0; i < 8; i++) hv[i] = SHA_H0[i];
    nbytes = '0;
  endtask

  // advance the predictor by one accepted word, queue digest words on end
  task automatic sha_absorb(input logic present, input logic [7:0] data, input logic eom);
    int pos;
    int sh;
    logic [63:0] bits;
    digest_exp_t e;
    if (present) begin
      pos = int'(nbytes[5:0]);
      place_byte(pos, {24'd0, data});
      nbytes = nbytes + 61'd1;
      if (pos == 63) sha_compress();
    end
    if (eom) begin
      pos = int'(nbytes[5:0]);
      place_byte(pos, 32'h80);
      sh = (3 - (pos & 3)) * 8;
      blk[pos >> 2] = blk[pos >> 2] & ~((32'd1 << sh) - 32'd1);
      for (int i = (pos >> 2) + 1; i < 16; i++) blk[i] = '0;
      // length field does not fit, spill into an extra block
      if (pos >= 56) begin
        sha_compress();
        for (int i = 0; i < 16; i++) blk[i] = '0;
      end
      bits = {nbytes, 3'b000};
      blk[14] = bits[63:32];
      blk[15] = bits[31:0];
      sha_compress();
      for (int i = 0; i < 8; i++) begin
        e.digest_word = hv[i];
        e.word_index = 3'(i);
        e.last_word = (i == 7);
        digest_q.push_back(e);
      end
      sha_restart();
    end
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] exp_v,
                                 input logic [31:0] got_v);
    $display("mismatch at result %0d: %s expected %h got %h", n_results, what, exp_v, got_v);
    n_errors++;
  endtask

  task automatic add_word(input logic [7:0] data, input logic present, input logic eom,
                          input pace_t phase);
    feed_t f;
    f.data = data;
    f.present = present;
    f.eom = eom;
    f.phase = phase;
    feed_q.push_back(f);
    counted++;
  endtask

  task automatic add_message(input int len, input pace_t phase, input logic split_end);
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(0, 19) == 0) add_word(8'($urandom), 1'b0, 1'b0, phase);
      add_word(8'($urandom), 1'b1, (i == len - 1) && !split_end, phase);
    end
    if (len == 0 || split_end) add_word(8'($urandom), 1'b0, 1'b1, phase);
  endtask

  // driver: presents words at the falling edge
  always @(negedge clk) begin : drv
    feed_t f;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || n_taken == n_sent) begin
      if (feed_q.size() != 0 && $urandom_range(0, 99) >= idle_pct(feed_q[0].phase)) begin
        f = feed_q.pop_front();
        in_valid <= 1'b1;
        in_data_byte <= f.data;
        in_byte_present <= f.present;
        in_end_of_message <= f.eom;
        cur_phase <= f.phase;
        n_sent <= n_sent + 1;
      end else begin
        in_valid <= 1'b0;
        in_data_byte <= 8'($urandom);
      end
    end
  end

  // long receiver hold-off once the directed words are through
  always @(negedge clk) begin
    if (rst_n && !hold_done && n_taken >= hold_at) begin
      hold_cnt <= hold_cnt + 1;
      if (hold_cnt == HOLD_LEN - 1) hold_done <= 1'b1;
    end
  end

  always @(negedge clk) begin
    out_ready <= rst_n && !(n_taken >= hold_at && !hold_done)
              && ($urandom_range(0, 99) >= stall_pct(cur_phase));
  end

  // monitor: results are checked before the input word is absorbed
  always @(posedge clk) begin : mon
    digest_exp_t e;
    logic moved;
    moved = 1'b0;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        moved = 1'b1;
        if (digest_q.size() == 0) begin
          report_mismatch("unexpected digest_word", 32'd0, out_digest_word);
        end else begin
          e = digest_q.pop_front();
          if (out_digest_word !== e.digest_word)
            report_mismatch("digest_word", e.digest_word, out_digest_word);
          if (out_word_index !== e.word_index)
            report_mismatch("word_index", 32'(e.word_index), 32'(out_word_index));
          if (out_last_word !== e.last_word)
            report_mismatch("last_word", 32'(e.last_word), 32'(out_last_word));
        end
        n_results++;
      end
      if (in_valid && in_ready) begin
        moved = 1'b1;
        n_taken++;
        if (in_byte_present) n_bytes++;
        if (in_end_of_message) n_msgs++;
        sha_absorb(in_byte_present, in_data_byte, in_end_of_message);
      end
      if (moved) begin
        stuck = 0;
      end else begin
        stuck++;
        if (stuck >= WATCHDOG) begin
          $display("watchdog: no word moved for %0d cycles", WATCHDOG);
          $display("[FAIL] regression broken");
          $finish;
        end
      end
    end
  end

  initial begin : main
    int len;
    int sel;
    int rand_start;
    pace_t ph;
    sha_restart();
    for (int i = 0; i < 16; i++) begin
      blk[i] = '0;
      wsched[i] = '0;
    end

    // directed: empty message, ignored byte, field extremes, end on its own word
    add_word(8'hff, 1'b0, 1'b1, PH_FREE);
    add_word(8'hff, 1'b0, 1'b0, PH_FREE);
    add_word(8'h00, 1'b1, 1'b0, PH_FREE);
    add_word(8'hff, 1'b1, 1'b0, PH_FREE);
    add_word(8'h80, 1'b1, 1'b1, PH_FREE);
    add_word(8'h61, 1'b1, 1'b0, PH_FREE);
    add_word(8'h62, 1'b1, 1'b0, PH_FREE);
    add_word(8'h63, 1'b1, 1'b1, PH_FREE);
    add_word(8'h00, 1'b0, 1'b0, PH_FREE);
    add_word(8'h01, 1'b1, 1'b0, PH_FREE);
    add_word(8'hfe, 1'b1, 1'b0, PH_FREE);
    add_word(8'h7f, 1'b1, 1'b0, PH_FREE);
    add_word(8'h55, 1'b1, 1'b0, PH_FREE);
    add_word(8'h00, 1'b0, 1'b1, PH_FREE);
    add_word(8'h00, 1'b1, 1'b1, PH_FREE);
    add_word(8'hff, 1'b0, 1'b1, PH_FREE);
    hold_at = feed_q.size();

    // burst of short messages while the receiver holds off
    for (int m = 0; m < 12; m++)
      add_message($urandom_range(0, 3), PH_FREE, 1'($urandom_range(0, 1)));

    rand_start = counted;
    while (counted < ITEM_GOAL) begin
      ph = pace_t'(((counted - rand_start) / 70) % 4);
      sel = $urandom_range(0, 9);
      if (sel < 4) len = $urandom_range(0, 12);
      else if (sel < 7) len = $urandom_range(52, 68);
      else if (sel < 9) len = $urandom_range(13, 51);
      else len = $urandom_range(110, 135);
      if (len > ITEM_GOAL - counted) len = ITEM_GOAL - counted;
      add_message(len, ph, $urandom_range(0, 3) == 0);
    end

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (feed_q.size() != 0 || n_taken != n_sent || digest_q.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    $display("hashed %0d messages, %0d bytes over %0d input words", n_msgs, n_bytes, n_taken);
    $display("checked %0d digest words, %0d mismatches", n_results, n_errors);
    if (n_errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+src
src/shabs_pkg.sv
src/shabs_ctrl.sv
src/shabs_dp.sv
src/sha256_byte_stream_hasher.sv
src/shabs_chk.sv
test/tb.sv
